// ===== hdl/forecast_oscillator_defines.svh =====
// Assertion macros used by the checker file of the forecast oscillator.
`ifndef FORECAST_OSCILLATOR_DEFINES_SVH
`define FORECAST_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FOSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("forecast oscillator check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FOSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("forecast oscillator check failed");

`endif

// ===== hdl/fosc_pkg.sv =====
// Package with the constants and control types of the forecast oscillator.
package fosc_pkg;
   localparam int MAX_PERIOD = 256;
   localparam int PTR_BITS = $clog2(MAX_PERIOD);
   localparam int PERIOD_BITS = 9;
   localparam int SAMPLE_BITS = 32;
   localparam int SUMY_BITS = 40;
   localparam int SUMXY_BITS = 48;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 9'd14;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MIN = 9'd2;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = 9'd256;
   localparam logic [22:0] PCT_Q16 = 23'd6553600;
   localparam int DIV_STEPS = 64;
   localparam int STEP_BITS = $clog2(DIV_STEPS);

   typedef struct packed {
      logic accept;
      logic update;
      logic prod;
      logic part;
      logic load_div;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic zero;
      logic rsp_busy;
   } status_type;
endpackage

// ===== hdl/fosc_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module fosc_ctrl
   import fosc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_PROD = 3'd2;
   localparam logic [2:0] S_PART = 3'd3;
   localparam logic [2:0] S_NUM  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.update = 1'b1;
            if (!status.full) begin
               state_in = S_IDLE;
            end else if (status.zero) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_PART;
         end
         S_PART: begin
            cmd.part = 1'b1;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.load_div = 1'b1;
            count_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// ===== hdl/fosc_datapath.sv =====
// Datapath with the sample ring, running sums, forecast products and divider.
module fosc_datapath
   import fosc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic                          csr_we,
   input  logic [PERIOD_BITS-1:0]        csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_oscillator,
   output logic                          rsp_zero_sample,
   output logic                          rsp_saturated
);
   logic [SAMPLE_BITS-1:0] ring [MAX_PERIOD];

   logic [PERIOD_BITS-1:0]        period_ff, fill_ff;
   logic [PTR_BITS-1:0]           wp_ff;
   logic signed [SUMY_BITS-1:0]   sy_ff;
   logic signed [SUMXY_BITS-1:0]  sxy_ff;
   logic signed [SAMPLE_BITS-1:0] s_ff, old_ff;
   logic                          zero_ff, full_ff, neg_ff;
   logic [15:0]                   q_ff;
   logic [63:0]                   t1_ff, t2_ff, t3_ff, magp_ff;
   logic [47:0]                   den_ff, rem_ff, rem_in;
   logic [54:0]                   lo_ff, hi_ff;
   logic [127:0]                  num_ff, num_in;
   logic                          rsp_valid_ff;
   logic signed [31:0]            osc_ff;
   logic                          zflag_ff, sat_ff;

   logic [PERIOD_BITS-1:0]        nm1, period_clamp;
   logic [17:0]                   q_full;
   logic signed [48:0]            m1;
   logic signed [49:0]            m2;
   logic signed [51:0]            m3;
   logic signed [41:0]            m4;
   logic [63:0]                   p_val, magp_val;
   logic [31:0]                   mags;
   logic [PTR_BITS-1:0]           rd_addr;
   logic [48:0]                   rs_a, rs_b;
   logic [47:0]                   rem_mid;
   logic [127:0]                  num_mid;
   logic                          qb_a, qb_b;
   logic [127:0]                  q_round;
   logic [31:0]                   limit, mag;
   logic                          sat_val;

   assign nm1 = period_ff - 1'b1;
   assign q_full = 18'(period_ff) * 18'(nm1);
   assign rd_addr = wp_ff - period_ff[PTR_BITS-1:0];

   assign m1 = 49'(s_ff) * 49'($signed({1'b0, q_ff}));
   assign m2 = 50'(sy_ff) * 50'($signed({1'b0, nm1}));
   assign m3 = 52'(sxy_ff) * 52'(4'sd6);
   assign m4 = 42'(old_ff) * 42'($signed({1'b0, period_ff}));

   assign p_val = t1_ff - t2_ff + t3_ff;
   assign magp_val = p_val[63] ? (64'd0 - p_val) : p_val;
   assign mags = s_ff[SAMPLE_BITS-1] ? (32'd0 - s_ff) : s_ff;

   always_comb begin
      if (csr_wdata < PERIOD_MIN) begin
         period_clamp = PERIOD_MIN;
      end else if (csr_wdata > PERIOD_MAX) begin
         period_clamp = PERIOD_MAX;
      end else begin
         period_clamp = csr_wdata;
      end
   end

   always_comb begin
      rs_a = {rem_ff, num_ff[127]};
      qb_a = (rs_a >= {1'b0, den_ff});
      rem_mid = qb_a ? 48'(rs_a - {1'b0, den_ff}) : rs_a[47:0];
      num_mid = {num_ff[126:0], qb_a};
      rs_b = {rem_mid, num_mid[127]};
      qb_b = (rs_b >= {1'b0, den_ff});
      rem_in = qb_b ? 48'(rs_b - {1'b0, den_ff}) : rs_b[47:0];
      num_in = {num_mid[126:0], qb_b};
   end

   always_comb begin
      q_round = num_ff + 128'({rem_ff, 1'b0} >= {1'b0, den_ff});
      limit = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat_val = (|q_round[127:32]) || (q_round[31:0] > limit);
      mag = sat_val ? limit : q_round[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         old_ff <= ring[rd_addr];
      end
      if (cmd.update) begin
         ring[wp_ff] <= s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         fill_ff <= '0;
         wp_ff <= '0;
         sy_ff <= '0;
         sxy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            period_ff <= period_clamp;
            fill_ff <= '0;
            sy_ff <= '0;
            sxy_ff <= '0;
         end else if (cmd.update) begin
            wp_ff <= wp_ff + 1'b1;
            if (full_ff) begin
               sxy_ff <= sxy_ff + {{8{sy_ff[SUMY_BITS-1]}}, sy_ff} - {{6{m4[41]}}, m4};
               sy_ff <= sy_ff - {{8{old_ff[31]}}, old_ff} + {{8{s_ff[31]}}, s_ff};
            end else begin
               sxy_ff <= sxy_ff + {{8{sy_ff[SUMY_BITS-1]}}, sy_ff};
               sy_ff <= sy_ff + {{8{s_ff[31]}}, s_ff};
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s_ff <= req_sample;
         zero_ff <= (req_sample == '0);
         full_ff <= (fill_ff >= period_ff);
         q_ff <= q_full[15:0];
      end
      if (cmd.update) begin
         t1_ff <= {{15{m1[48]}}, m1};
         t2_ff <= {{12{m2[49]}}, m2, 2'b00};
         t3_ff <= {{12{m3[51]}}, m3};
      end
      if (cmd.prod) begin
         magp_ff <= magp_val;
         neg_ff <= p_val[63] ^ s_ff[SAMPLE_BITS-1];
         den_ff <= 48'(mags) * 48'(q_ff);
      end
      if (cmd.part) begin
         lo_ff <= 55'(magp_ff[31:0]) * 55'(PCT_Q16);
         hi_ff <= 55'(magp_ff[63:32]) * 55'(PCT_Q16);
      end
      if (cmd.load_div) begin
         num_ff <= 128'({hi_ff, 32'd0}) + 128'(lo_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         zflag_ff <= zero_ff;
         sat_ff <= zero_ff ? 1'b0 : sat_val;
         osc_ff <= zero_ff ? 32'sd0 : (neg_ff ? (32'd0 - mag) : mag);
      end
   end

   assign status.full = full_ff;
   assign status.zero = zero_ff;
   assign status.rsp_busy = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_oscillator = osc_ff;
   assign rsp_zero_sample = zflag_ff;
   assign rsp_saturated = sat_ff;
endmodule

// ===== hdl/forecast_oscillator.sv =====
// Top level of the forecast oscillator. A full-window request runs the load, product,
// partial, numerator and divide states, then waits in done until the last response is taken;
// a zero sample goes from load to done. The 128-bit restoring divider retires two quotient
// bits a cycle. Only an idle controller takes a request; warm-up requests give no result.
// Reset is synchronous and active high; it sets the period to 14 and empties the window.
module forecast_oscillator
   import fosc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_oscillator,
   output logic                          rsp_zero_sample,
   output logic                          rsp_saturated,
   input  logic                          csr_we,
   input  logic [PERIOD_BITS-1:0]        csr_wdata
);
   cmd_type    cmd;
   status_type status;

   fosc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fosc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_oscillator  (rsp_oscillator),
      .rsp_zero_sample (rsp_zero_sample),
      .rsp_saturated   (rsp_saturated)
   );
endmodule

// ===== hdl/fosc_checker.sv =====
// Port-level checker for the forecast oscillator and its bind.
`include "forecast_oscillator_defines.svh"

module fosc_checker
   import fosc_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [SAMPLE_BITS-1:0] req_sample,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [31:0]            rsp_oscillator,
   input logic                          rsp_zero_sample,
   input logic                          rsp_saturated
);
   logic req_fire;
   logic [31:0] osc_bits;

   assign req_fire = req_valid && req_ready && (req_sample == req_sample);
   assign osc_bits = rsp_oscillator;

   `FOSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `FOSC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_ready)
   `FOSC_ASSERT_SAME(a_zero_result, clock, reset, rsp_valid && rsp_zero_sample, osc_bits == 32'd0 && !rsp_saturated)
   `FOSC_ASSERT_SAME(a_sat_limit, clock, reset, rsp_valid && rsp_saturated, osc_bits == 32'h7FFF_FFFF || osc_bits == 32'h8000_0000)
endmodule

bind forecast_oscillator fosc_checker u_fosc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_sample      (req_sample),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_oscillator  (rsp_oscillator),
   .rsp_zero_sample (rsp_zero_sample),
   .rsp_saturated   (rsp_saturated)
);
